// ===== sv/htbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htbm_pkg
// types and constants shared by the byte meter front end, queue and counters
// ----------------------------------------------------------------------------
package htbm_pkg;

  localparam int OUT_WIDTH    = 40;
  localparam int AMOUNT_WIDTH = 16;
  localparam int POS_WIDTH    = 6;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_WIDTH   = 2;
  localparam int QCNT_WIDTH   = 3;

  localparam logic [15:0] ETHER_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'h06;
  localparam logic [7:0]  PROTO_UDP  = 8'h11;
  localparam logic [3:0]  NIBBLE_MASK = 4'hf;
  localparam logic [7:0]  UDP_HEADER_BYTES = 8'd8;

  localparam logic [POS_WIDTH-1:0] POS_LIMIT      = 6'd63;
  localparam logic [POS_WIDTH-1:0] POS_KIND_HI    = 6'd12;
  localparam logic [POS_WIDTH-1:0] POS_KIND_LO    = 6'd13;
  localparam logic [POS_WIDTH-1:0] POS_IHL        = 6'd14;
  localparam logic [POS_WIDTH-1:0] POS_LEN_HI     = 6'd16;
  localparam logic [POS_WIDTH-1:0] POS_LEN_LO     = 6'd17;
  localparam logic [POS_WIDTH-1:0] POS_PROTO      = 6'd23;
  localparam logic [POS_WIDTH-1:0] POS_SRC_FIRST  = 6'd26;
  localparam logic [POS_WIDTH-1:0] POS_SRC_LAST   = 6'd29;
  localparam logic [POS_WIDTH-1:0] POS_DST_FIRST  = 6'd30;
  localparam logic [POS_WIDTH-1:0] POS_DST_LAST   = 6'd33;
  localparam logic [POS_WIDTH-1:0] POS_SEG_OFFSET = 6'd46;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic ADDR_HOST = 1'b0;

  typedef struct packed {
    logic                    is_tick;
    logic [AMOUNT_WIDTH-1:0] amount;
    logic                    src_hit;
    logic                    dst_hit;
  } entry_t;

endpackage
`default_nettype wire

// ===== sv/host_traffic_byte_meter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// host_traffic_byte_meter
// meters host tcp/udp payload bytes from a stream of ethernet frame bytes
// a tick is written to a queue slot, and its result then goes to the result register
// throughput: one item per cycle while the queue is not full, the front end taking one byte a cycle
// the four-entry queue stalls input only while the result register is held
// reset: synchronous rst clears counters, parser position, queue and host_address
// ----------------------------------------------------------------------------
module host_traffic_byte_meter #(
  parameter int COUNT_WIDTH = 40
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      req_type,
  input  wire logic [7:0]                frame_byte,
  input  wire logic                      frame_end,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [htbm_pkg::OUT_WIDTH-1:0] sent_bytes,
  output logic [htbm_pkg::OUT_WIDTH-1:0] received_bytes
);
  import htbm_pkg::*;

  logic [31:0] host_address;
  logic        queue_full;
  logic        queue_not_empty;
  logic        push;
  logic        pop;
  entry_t      push_entry;
  entry_t      pop_entry;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_HOST) ? host_address : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      host_address <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_HOST)) begin
      host_address <= pwdata;
    end
  end

  htbm_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .frame_byte   (frame_byte),
    .frame_end    (frame_end),
    .host_address (host_address),
    .queue_full   (queue_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  htbm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .not_empty  (queue_not_empty),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  htbm_count #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_count (
    .clk            (clk),
    .rst            (rst),
    .entry_valid    (queue_not_empty),
    .entry          (pop_entry),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sent_bytes     (sent_bytes),
    .received_bytes (received_bytes)
  );

endmodule
`default_nettype wire

// ===== sv/htbm_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htbm_parse
// front end: takes frame bytes and ticks, captures the header fields and
// queues one entry per tick and per metered frame
// ----------------------------------------------------------------------------
module htbm_parse (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              req_type,
  input  wire logic [7:0]        frame_byte,
  input  wire logic              frame_end,
  input  wire logic [31:0]       host_address,
  input  wire logic              queue_full,
  output logic                   push,
  output htbm_pkg::entry_t       push_entry
);
  import htbm_pkg::*;

  logic [POS_WIDTH-1:0] byte_position;
  logic [15:0]          ether_kind;
  logic [3:0]           header_words;
  logic [15:0]          total_length;
  logic [7:0]           protocol_number;
  logic [31:0]          source_address;
  logic [31:0]          dest_address;
  logic [3:0]           segment_offset;

  logic       accept;
  logic       byte_accept;
  logic [3:0] offset_now;
  logic [7:0] deduct;
  logic [16:0] length_ext;
  logic [16:0] deduct_ext;
  logic       is_tcp;
  logic       is_udp;
  logic       frame_done;

  assign in_ready    = !queue_full;
  assign accept      = in_valid && in_ready;
  assign byte_accept = accept && (req_type == REQ_BYTE);

  // the data offset byte can be the last byte of the frame itself
  assign offset_now = (byte_position == POS_SEG_OFFSET) ? frame_byte[7:4] : segment_offset;

  assign is_tcp = (protocol_number == PROTO_TCP);
  assign is_udp = (protocol_number == PROTO_UDP);

  always_comb begin
    deduct     = {2'b00, header_words, 2'b00} +
                 (is_tcp ? {2'b00, offset_now, 2'b00} : UDP_HEADER_BYTES);
    length_ext = {1'b0, total_length};
    deduct_ext = {9'd0, deduct};
    frame_done = byte_accept && frame_end && (byte_position >= POS_SEG_OFFSET) &&
                 (ether_kind == ETHER_IPV4) && (is_tcp || is_udp);
    push_entry.is_tick = 1'b0;
    push_entry.amount  = '0;
    push_entry.src_hit = (source_address == host_address);
    push_entry.dst_hit = (dest_address == host_address);
    if (length_ext > deduct_ext) begin
      push_entry.amount = total_length - {8'd0, deduct};
    end
    if (req_type == REQ_TICK) begin
      push_entry.is_tick = 1'b1;
      push_entry.src_hit = 1'b0;
      push_entry.dst_hit = 1'b0;
    end
    push = (accept && (req_type == REQ_TICK)) || frame_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      ether_kind      <= '0;
      header_words    <= '0;
      total_length    <= '0;
      protocol_number <= '0;
      source_address  <= '0;
      dest_address    <= '0;
      segment_offset  <= '0;
    end else if (byte_accept) begin
      if (byte_position < POS_LIMIT) begin
        byte_position <= byte_position + 1'b1;
        if (byte_position == POS_KIND_HI || byte_position == POS_KIND_LO) begin
          ether_kind <= {ether_kind[7:0], frame_byte};
        end
        if (byte_position == POS_IHL) begin
          header_words <= frame_byte[3:0] & NIBBLE_MASK;
        end
        if (byte_position == POS_LEN_HI || byte_position == POS_LEN_LO) begin
          total_length <= {total_length[7:0], frame_byte};
        end
        if (byte_position == POS_PROTO) begin
          protocol_number <= frame_byte;
        end
        if (byte_position >= POS_SRC_FIRST && byte_position <= POS_SRC_LAST) begin
          source_address <= {source_address[23:0], frame_byte};
        end
        if (byte_position >= POS_DST_FIRST && byte_position <= POS_DST_LAST) begin
          dest_address <= {dest_address[23:0], frame_byte};
        end
        if (byte_position == POS_SEG_OFFSET) begin
          segment_offset <= frame_byte[7:4];
        end
      end
      if (frame_end) begin
        byte_position <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/htbm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htbm_queue
// short fifo between the front end and the counters
// ----------------------------------------------------------------------------
module htbm_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire htbm_pkg::entry_t push_entry,
  output logic                  full,
  output logic                  not_empty,
  input  wire logic             pop,
  output htbm_pkg::entry_t      pop_entry
);
  import htbm_pkg::*;

  entry_t                slots [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QCNT_WIDTH-1:0] count;

  assign full      = (count == QCNT_WIDTH'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, pop && not_empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/htbm_count.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htbm_count
// back end: saturating interval counters and the result register
// ----------------------------------------------------------------------------
module htbm_count #(
  parameter int COUNT_WIDTH = 40
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         entry_valid,
  input  wire htbm_pkg::entry_t             entry,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [htbm_pkg::OUT_WIDTH-1:0]    sent_bytes,
  output logic [htbm_pkg::OUT_WIDTH-1:0]    received_bytes
);
  import htbm_pkg::*;

  logic [COUNT_WIDTH-1:0] sent_count;
  logic [COUNT_WIDTH-1:0] received_count;
  logic [COUNT_WIDTH-1:0] sent_next;
  logic [COUNT_WIDTH-1:0] received_next;
  logic [COUNT_WIDTH:0]   sent_sum;
  logic [COUNT_WIDTH:0]   received_sum;
  logic [63:0]            sent_wide;
  logic [63:0]            received_wide;
  logic                   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign pop       = entry_valid && (!entry.is_tick || slot_free);

  always_comb begin
    sent_sum      = {1'b0, sent_count} + (COUNT_WIDTH + 1)'(entry.amount);
    received_sum  = {1'b0, received_count} + (COUNT_WIDTH + 1)'(entry.amount);
    sent_next     = sent_sum[COUNT_WIDTH] ? '1 : sent_sum[COUNT_WIDTH-1:0];
    received_next = received_sum[COUNT_WIDTH] ? '1 : received_sum[COUNT_WIDTH-1:0];
    sent_wide     = 64'(sent_count);
    received_wide = 64'(received_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_count     <= '0;
      received_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (entry.is_tick) begin
          sent_count     <= '0;
          received_count <= '0;
          out_valid      <= 1'b1;
        end else begin
          if (entry.src_hit) begin
            sent_count <= sent_next;
          end
          if (entry.dst_hit) begin
            received_count <= received_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && entry.is_tick) begin
      sent_bytes     <= sent_wide[OUT_WIDTH-1:0];
      received_bytes <= received_wide[OUT_WIDTH-1:0];
    end
  end

  a_tick_clears: assert property (@(posedge clk) disable iff (rst)
    pop && entry.is_tick |=> sent_count == '0 && received_count == '0)
    else $error("counters not cleared by tick");

  a_tick_slot: assert property (@(posedge clk) disable iff (rst)
    pop && entry.is_tick |-> slot_free)
    else $error("tick taken while result still pending");

  a_sent_grows: assert property (@(posedge clk) disable iff (rst)
    !(pop && entry.is_tick) |=> $past(rst) || sent_count >= $past(sent_count))
    else $error("sent count dropped without tick");

  a_recv_grows: assert property (@(posedge clk) disable iff (rst)
    !(pop && entry.is_tick) |=> $past(rst) || received_count >= $past(received_count))
    else $error("received count dropped without tick");

endmodule
`default_nettype wire

// ===== dv/host_traffic_byte_meter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// host_traffic_byte_meter_tb
// drives ethernet frame bytes and ticks into the byte meter,
// tracks the tcp/udp payload tallies of the host in a local model and checks
// every interval report field by field, under random gaps, receiver stalls
// and a long receiver hold-off that fills the entry queue
// ----------------------------------------------------------------------------
module host_traffic_byte_meter_tb;
  import htbm_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;
  localparam logic [2:0] HOST_OFFSET = {ADDR_HOST, 2'b00};

  typedef struct packed {
    logic [OUT_WIDTH-1:0] sent;
    logic [OUT_WIDTH-1:0] recv;
  } tally_t;

  typedef struct {
    int          len;
    logic [15:0] kind;
    logic [7:0]  ihl_byte;
    logic [15:0] total;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  off_byte;
    int          tick_at;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = REQ_BYTE;
  logic [7:0] frame_byte = '0;
  logic frame_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUT_WIDTH-1:0] sent_bytes;
  logic [OUT_WIDTH-1:0] received_bytes;

  host_traffic_byte_meter dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .frame_byte(frame_byte),
    .frame_end(frame_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sent_bytes(sent_bytes),
    .received_bytes(received_bytes)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // local copy of the parser and counters
  logic [31:0]          host_addr = '0;
  logic [POS_WIDTH-1:0] seen_pos = '0;
  logic [15:0]          seen_kind = '0;
  logic [3:0]           seen_ihl = '0;
  logic [15:0]          seen_total = '0;
  logic [7:0]           seen_proto = '0;
  logic [31:0]          seen_src = '0;
  logic [31:0]          seen_dst = '0;
  logic [3:0]           seen_offset = '0;
  logic [OUT_WIDTH-1:0] sent_tally = '0;
  logic [OUT_WIDTH-1:0] recv_tally = '0;

  tally_t pending_tallies[$];
  tally_t oldest_tally;

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned reports_checked = 0;
  int unsigned host_settings = 0;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  logic hold_on = 1'b0;
  int rx_stall_left = 0;
  event hold_go;

  task automatic report_mismatch(input string what, input logic [OUT_WIDTH-1:0] got,
                                 input logic [OUT_WIDTH-1:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [OUT_WIDTH-1:0] add_saturated(input logic [OUT_WIDTH-1:0] acc,
                                                         input logic [OUT_WIDTH-1:0] amt);
    logic [OUT_WIDTH:0] sum;
    sum = {1'b0, acc} + {1'b0, amt};
    return sum[OUT_WIDTH] ? '1 : sum[OUT_WIDTH-1:0];
  endfunction

  task automatic close_frame();
    int len;
    logic [OUT_WIDTH-1:0] amount;
    if (seen_kind != ETHER_IPV4) return;
    if (seen_proto == PROTO_TCP)
      len = int'(seen_total) - 4 * int'(seen_ihl) - 4 * int'(seen_offset);
    else if (seen_proto == PROTO_UDP)
      len = int'(seen_total) - 4 * int'(seen_ihl) - int'(UDP_HEADER_BYTES);
    else
      return;
    amount = (len > 0) ? OUT_WIDTH'(len) : '0;
    if (seen_src == host_addr) sent_tally = add_saturated(sent_tally, amount);
    if (seen_dst == host_addr) recv_tally = add_saturated(recv_tally, amount);
  endtask

  task automatic meter_item(input logic kind, input logic [7:0] b, input logic last);
    logic [POS_WIDTH-1:0] pos;
    if (kind == REQ_TICK) begin
      pending_tallies.push_back('{sent: sent_tally, recv: recv_tally});
      sent_tally = '0;
      recv_tally = '0;
      return;
    end
    pos = seen_pos;
    if (pos < POS_LIMIT) begin
      if (pos == POS_KIND_HI || pos == POS_KIND_LO) seen_kind = {seen_kind[7:0], b};
      else if (pos == POS_IHL) seen_ihl = b[3:0] & NIBBLE_MASK;
      else if (pos == POS_LEN_HI || pos == POS_LEN_LO) seen_total = {seen_total[7:0], b};
      else if (pos == POS_PROTO) seen_proto = b;
      else if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) seen_src = {seen_src[23:0], b};
      else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) seen_dst = {seen_dst[23:0], b};
      else if (pos == POS_SEG_OFFSET) seen_offset = b[7:4] & NIBBLE_MASK;
      seen_pos = pos + 1'b1;
    end
    if (last) begin
      if (pos >= POS_SEG_OFFSET) close_frame();
      seen_pos = '0;
    end
  endtask

  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(input logic kind, input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap(tx_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    frame_byte <= b;
    frame_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    meter_item(kind, b, last);
    items_sent++;
    if (kind == REQ_TICK) ticks_sent++;
  endtask

  task automatic send_tick();
    send_item(REQ_TICK, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_frame(input frame_t f);
    logic [7:0] b;
    for (int i = 0; i < f.len; i++) begin
      b = 8'($urandom);
      case (i)
        12: b = f.kind[15:8];
        13: b = f.kind[7:0];
        14: b = f.ihl_byte;
        16: b = f.total[15:8];
        17: b = f.total[7:0];
        23: b = f.proto;
        26, 27, 28, 29: b = f.src[8*(29-i) +: 8];
        30, 31, 32, 33: b = f.dst[8*(33-i) +: 8];
        46: b = f.off_byte;
        default: ;
      endcase
      if (i == f.tick_at) send_tick();
      send_item(REQ_BYTE, b, i == f.len - 1);
    end
    frames_sent++;
  endtask

  function automatic frame_t make_frame(input int len, input logic [15:0] kind,
                                        input logic [7:0] proto, input logic [31:0] src,
                                        input logic [31:0] dst, input logic [15:0] total,
                                        input logic [7:0] ihl_byte, input logic [7:0] off_byte);
    frame_t f;
    f.len = len;
    f.kind = kind;
    f.proto = proto;
    f.src = src;
    f.dst = dst;
    f.total = total;
    f.ihl_byte = ihl_byte;
    f.off_byte = off_byte;
    f.tick_at = -1;
    return f;
  endfunction

  function automatic logic [31:0] pick_address();
    int r;
    r = $urandom_range(99);
    if (r < 45) return host_addr;
    if (r < 55) return host_addr ^ (32'd1 << $urandom_range(31));
    return $urandom;
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    int r;
    r = $urandom_range(99);
    f.len = (r < 75) ? $urandom_range(47, 50) : (r < 88) ? $urandom_range(1, 46)
          : $urandom_range(51, 90);
    f.kind = ($urandom_range(99) < 85) ? ETHER_IPV4 : 16'($urandom);
    r = $urandom_range(99);
    f.proto = (r < 45) ? PROTO_TCP : (r < 90) ? PROTO_UDP : 8'($urandom);
    f.src = pick_address();
    f.dst = pick_address();
    f.total = ($urandom_range(99) < 40) ? 16'($urandom_range(0, 120)) : 16'($urandom);
    f.ihl_byte = 8'($urandom);
    f.off_byte = 8'($urandom);
    f.tick_at = ($urandom_range(99) < 15) ? $urandom_range(0, f.len - 1) : -1;
    return f;
  endfunction

  task automatic write_host(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= HOST_OFFSET;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    host_addr = value;
    host_settings++;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== host_addr) report_mismatch("host_address readback", prdata, host_addr);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_tallies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_tallies.size() != 0)
      report_mismatch("results never arrived", OUT_WIDTH'(pending_tallies.size()), '0);
    repeat (8) @(posedge clk);
  endtask

  // receiver side
  always @(posedge clk) begin
    if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_ready <= 1'b0;
    end else if (rx_idle && $urandom_range(99) < 20) begin
      rx_stall_left <= ($urandom_range(99) < 90) ? $urandom_range(0, 3) : $urandom_range(15, 50);
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_on;
    end
  end

  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_tallies.size() == 0) begin
        report_mismatch("unexpected result", sent_bytes, '0);
      end else begin
        oldest_tally = pending_tallies.pop_front();
        if (sent_bytes !== oldest_tally.sent)
          report_mismatch("sent_bytes", sent_bytes, oldest_tally.sent);
        if (received_bytes !== oldest_tally.recv)
          report_mismatch("received_bytes", received_bytes, oldest_tally.recv);
        reports_checked++;
      end
    end
  end

  task automatic test_reset_state();
    send_tick();
    send_frame(make_frame(47, ETHER_IPV4, PROTO_UDP, '0, '0, 16'd100, 8'h45, 8'h50));
    send_tick();
    wait_drained();
  endtask

  task automatic test_payload_counts();
    logic [31:0] other;
    write_host(32'hC0A80164);
    other = 32'h0A000001;
    send_frame(make_frame(54, ETHER_IPV4, PROTO_TCP, host_addr, other, 16'd1500, 8'h45, 8'h50));
    send_frame(make_frame(47, ETHER_IPV4, PROTO_UDP, other, host_addr, 16'd100, 8'h45, 8'h00));
    send_frame(make_frame(47, ETHER_IPV4, PROTO_UDP, host_addr, host_addr, 16'hFFFF, 8'h40, 8'hFF));
    send_frame(make_frame(48, ETHER_IPV4, PROTO_TCP, host_addr, other, 16'hFFFF, 8'h40, 8'h0F));
    send_tick();
    wait_drained();
  endtask

  task automatic test_special_frames();
    frame_t f;
    write_host(32'hFFFFFFFF);
    // two short frames, then a long frame with zero payload length
    send_frame(make_frame(46, ETHER_IPV4, PROTO_TCP, host_addr, host_addr, 16'd900, 8'h45, 8'h50));
    send_frame(make_frame(1, ETHER_IPV4, PROTO_TCP, host_addr, host_addr, 16'd900, 8'h45, 8'h50));
    send_frame(make_frame(90, ETHER_IPV4, PROTO_UDP, '0, host_addr, 16'd28, 8'h45, 8'h00));
    // other ethertype and other protocol
    send_frame(make_frame(47, 16'h86DD, PROTO_TCP, host_addr, host_addr, 16'd900, 8'h45, 8'h50));
    send_frame(make_frame(47, ETHER_IPV4, 8'h01, host_addr, host_addr, 16'd900, 8'h45, 8'h50));
    // negative length
    send_frame(make_frame(47, ETHER_IPV4, PROTO_TCP, host_addr, host_addr, 16'd10, 8'h4F, 8'hF0));
    send_tick();
    // tick in the middle of a frame
    f = make_frame(48, ETHER_IPV4, PROTO_UDP, host_addr, '0, 16'd200, 8'h45, 8'h00);
    f.tick_at = 20;
    send_frame(f);
    f.tick_at = 47;
    send_frame(f);
    send_tick();
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    write_host(32'h0A0B0C0D);
    -> hold_go;
    for (int k = 0; k < 2; k++) begin
      send_frame(make_frame(47, ETHER_IPV4, PROTO_UDP, host_addr, 32'($urandom),
                            16'(100 + k), 8'h45, 8'h00));
      send_tick();
    end
    repeat (6) send_tick();
    wait_drained();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned phase_items;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_host('0);
        1: write_host(32'hFFFFFFFF);
        default: write_host($urandom);
      endcase
      tx_idle = (phase != 1);
      rx_idle = (phase != 1);
      phase_items = items_sent;
      while (items_sent - phase_items < 15) begin
        if ($urandom_range(99) < 45) send_tick();
        else send_frame(random_frame());
      end
      send_tick();
      wait_drained();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_payload_counts();
    test_special_frames();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk);
    $display("sent %0d items (%0d frames, %0d ticks), checked %0d interval reports",
             items_sent, frames_sent, ticks_sent, reports_checked);
    $display("%0d host address settings, with stalls, gaps and a full-queue hold-off",
             host_settings);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("timeout with %0d results outstanding", pending_tallies.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
sv/htbm_pkg.sv
sv/htbm_parse.sv
sv/htbm_queue.sv
sv/htbm_count.sv
sv/host_traffic_byte_meter.sv
dv/host_traffic_byte_meter_tb.sv
